// ----- rtl/pfx_pkg.sv -----
// Shared constants, codes, types and helpers of the postfix expression evaluator.
`timescale 1ns / 1ps

package pfx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = $clog2(DATA_W);

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_OPER = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
    localparam logic [1:0] ERR_DIVZERO   = 2'd3;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

    function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

// ----- rtl/pfx_alu.sv -----
// Iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
`timescale 1ns / 1ps

module pfx_alu
    import pfx_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  alu_req_t                 req,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output alu_rsp_t                 rsp,
    output logic signed [DATA_W-1:0] result
);

    typedef enum logic [7:0] {
        A_IDLE   = 8'b0000_0001,
        A_ADDSUB = 8'b0000_0010,
        A_MUL    = 8'b0000_0100,
        A_NEGL   = 8'b0000_1000,
        A_NEGR   = 8'b0001_0000,
        A_DIV    = 8'b0010_0000,
        A_FIX    = 8'b0100_0000,
        A_DONE   = 8'b1000_0000
    } alu_state_t;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    alu_state_t        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] m_reg, m_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              dz_reg, dz_next;

    logic [DATA_W:0]   add_x, add_y;
    logic              add_cin;
    logic [DATA_W+1:0] add_sum;

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(DATA_W + 1){1'b0}}, add_cin};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        m_next     = m_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        dz_next    = dz_reg;
        add_x      = '0;
        add_y      = '0;
        add_cin    = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    q_next   = a;
                    m_next   = b;
                    acc_next = '0;
                    cnt_next = '0;
                    neg_next = a[DATA_W-1] ^ b[DATA_W-1];
                    dz_next  = 1'b0;
                    unique case (req.op)
                        OP_ADD, OP_SUB: state_next = A_ADDSUB;
                        OP_MUL:         state_next = A_MUL;
                        default:
                        begin
                            if (b == '0)
                            begin
                                dz_next    = 1'b1;
                                state_next = A_DONE;
                            end
                            else
                            begin
                                state_next = A_NEGL;
                            end
                        end
                    endcase
                end
            end
            A_ADDSUB:
            begin
                add_x      = {1'b0, q_reg};
                add_y      = (op_reg == OP_SUB) ? {1'b0, ~m_reg} : {1'b0, m_reg};
                add_cin    = (op_reg == OP_SUB);
                acc_next   = add_sum[DATA_W-1:0];
                state_next = A_DONE;
            end
            A_MUL:
            begin
                add_x = {1'b0, acc_reg};
                add_y = {1'b0, m_reg};
                if (q_reg[0])
                begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                m_next   = {m_reg[DATA_W-2:0], 1'b0};
                q_next   = {1'b0, q_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = A_DONE;
                end
            end
            A_NEGL:
            begin
                add_y   = {1'b0, ~q_reg};
                add_cin = 1'b1;
                if (q_reg[DATA_W-1])
                begin
                    q_next = add_sum[DATA_W-1:0];
                end
                state_next = A_NEGR;
            end
            A_NEGR:
            begin
                add_y   = {1'b0, ~m_reg};
                add_cin = 1'b1;
                if (m_reg[DATA_W-1])
                begin
                    m_next = add_sum[DATA_W-1:0];
                end
                state_next = A_DIV;
            end
            A_DIV:
            begin
                add_x   = {acc_reg, q_reg[DATA_W-1]};
                add_y   = ~{1'b0, m_reg};
                add_cin = 1'b1;
                if (add_sum[DATA_W+1])
                begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                else
                begin
                    acc_next = {acc_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                end
                q_next   = {q_reg[DATA_W-2:0], add_sum[DATA_W+1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                add_y      = neg_reg ? {1'b0, ~q_reg} : {1'b0, q_reg};
                add_cin    = neg_reg;
                acc_next   = add_sum[DATA_W-1:0];
                state_next = A_DONE;
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        m_reg   <= m_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        dz_reg  <= dz_next;
    end

    assign rsp.done     = (state_reg == A_DONE);
    assign rsp.div_zero = dz_reg;
    assign result       = acc_reg;

endmodule

// ----- rtl/postfix_expression_evaluator.sv -----
// Top level of the postfix expression evaluator: token sequencer, operand stack, result register.
`timescale 1ns / 1ps

// Tokens arrive one at a time on the input channel and the block is busy until each is
// finished. A push completes in the idle state. An operator pops two operands from the
// on-chip stack (two registered reads), runs on the shared iterative unit and writes the
// result back: add and subtract go straight through the adder, multiply takes one shift-add
// step per bit, divide does magnitude conversion, one restoring step per bit and a sign fix,
// or goes straight to done with a zero divisor. An end token loads the answer and status into
// the output register; the next token is accepted while that result waits. The stack needs no clearing after reset.
module postfix_expression_evaluator
    import pfx_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               command,
    input  logic signed [DATA_W-1:0] value,
    input  logic [1:0]               op,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] answer,
    output logic [1:0]               status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD_L = 5'b00010,
        S_LOAD = 5'b00100,
        S_EXEC = 5'b01000,
        S_END  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  count_reg, count_next;
    logic [1:0]        err_reg, err_next;
    logic [1:0]        op_reg, op_next;
    logic [DATA_W-1:0] right_reg, right_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] answer_reg, answer_next;
    logic [1:0]        status_reg, status_next;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_we;

    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;
    logic signed [DATA_W-1:0] alu_result;

    pfx_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (mem_rdata_reg),
        .b      (right_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        right_next     = right_reg;
        out_valid_next = out_valid_reg && !out_ready;
        answer_next    = answer_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[ADDR_W-1:0];
        mem_wdata      = value;
        mem_raddr      = ADDR_W'(count_reg - PTR_W'(1));
        alu_req        = '0;
        alu_req.op     = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        CMD_PUSH:
                        begin
                            if (count_reg == PTR_W'(STACK_DEPTH))
                            begin
                                err_next = note_err(err_reg, ERR_OVERFLOW);
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + PTR_W'(1);
                            end
                        end
                        CMD_OPER:
                        begin
                            if (count_reg < PTR_W'(2))
                            begin
                                err_next = note_err(err_reg, ERR_UNDERFLOW);
                            end
                            else
                            begin
                                op_next    = op;
                                state_next = S_RD_L;
                            end
                        end
                        CMD_END:
                        begin
                            state_next = S_END;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_L:
            begin
                mem_raddr  = ADDR_W'(count_reg - PTR_W'(2));
                right_next = mem_rdata_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                alu_req.start = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ADDR_W'(count_reg - PTR_W'(2));
                    mem_wdata  = alu_result;
                    count_next = count_reg - PTR_W'(1);
                    if (alu_rsp.div_zero)
                    begin
                        err_next = note_err(err_reg, ERR_DIVZERO);
                    end
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        answer_next = '0;
                        status_next = note_err(err_reg, ERR_UNDERFLOW);
                    end
                    else
                    begin
                        answer_next = mem_rdata_reg;
                        status_next = err_reg;
                    end
                    count_next = '0;
                    err_next   = ERR_NONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= stack_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        right_reg  <= right_next;
        answer_reg <= answer_next;
        status_reg <= status_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

endmodule

// ----- rtl/pfx_checker.sv -----
// Port-level checks of the postfix expression evaluator and their binding to the top level.
`timescale 1ns / 1ps

module pfx_checker
    import pfx_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [1:0]               command,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] answer,
    input logic [1:0]               status
);

    // hold a pending result until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(status))
        else $error("result changed or dropped before transfer");

    a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_PUSH |=> in_ready)
        else $error("push transfer stalled the input");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_END |=> !in_ready)
        else $error("end transfer did not occupy the block");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without end processing");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .answer    (answer),
    .status    (status)
);

// ----- test/postfix_expression_evaluator_test.sv -----
// Self-checking testbench for the postfix expression evaluator with a token-level stack predictor.
`timescale 1ns / 1ps

module postfix_expression_evaluator_test;
    import pfx_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 633;
    localparam int TAIL_CYCLES    = 120;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] value;
        logic [1:0]        op;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0] answer;
        logic [1:0]        status;
    } outcome_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               command = CMD_PUSH;
    logic signed [DATA_W-1:0] value = '0;
    logic [1:0]               op = OP_ADD;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] answer;
    logic [1:0]               status;

    token_t   token_q[$];
    outcome_t pending_answers[$];
    token_t   next_token;
    outcome_t want;
    logic     in_taken = 1'b0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       item_count = 0;
    int       errors = 0;
    int       quiet_cycles = 0;

    logic [DATA_W-1:0] stack_model [STACK_DEPTH];
    int                depth_model = 0;
    logic [1:0]        err_model = ERR_NONE;

    postfix_expression_evaluator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .answer    (answer),
        .status    (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic record_error(input logic [1:0] code);
        if (err_model == ERR_NONE)
            err_model = code;
    endtask

    task automatic stack_push(input logic [DATA_W-1:0] v);
        if (depth_model >= STACK_DEPTH)
        begin
            record_error(ERR_OVERFLOW);
        end
        else
        begin
            stack_model[depth_model] = v;
            depth_model++;
        end
    endtask

    function automatic logic [DATA_W-1:0] quotient_trunc(input logic [DATA_W-1:0] l,
                                                         input logic [DATA_W-1:0] r);
        logic [DATA_W-1:0] ml;
        logic [DATA_W-1:0] mr;
        logic [DATA_W-1:0] q;
        ml = l[DATA_W-1] ? -l : l;
        mr = r[DATA_W-1] ? -r : r;
        q  = ml / mr;
        return (l[DATA_W-1] != r[DATA_W-1]) ? -q : q;
    endfunction

    task automatic evaluate_token(input token_t t);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        outcome_t          o;
        case (t.command)
            CMD_PUSH:
            begin
                stack_push(t.value);
            end
            CMD_OPER:
            begin
                if (depth_model < 2)
                begin
                    record_error(ERR_UNDERFLOW);
                end
                else
                begin
                    rhs = stack_model[depth_model - 1];
                    lhs = stack_model[depth_model - 2];
                    depth_model -= 2;
                    case (t.op)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        default:
                        begin
                            if (rhs == '0)
                            begin
                                record_error(ERR_DIVZERO);
                                res = '0;
                            end
                            else
                            begin
                                res = quotient_trunc(lhs, rhs);
                            end
                        end
                    endcase
                    stack_push(res);
                end
            end
            CMD_END:
            begin
                o.answer = '0;
                if (depth_model == 0)
                    record_error(ERR_UNDERFLOW);
                else
                    o.answer = stack_model[depth_model - 1];
                o.status = err_model;
                pending_answers.push_back(o);
                depth_model = 0;
                err_model   = ERR_NONE;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return DATA_W'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_token(input token_t t);
        token_q.push_back(t);
        if (t.command != CMD_UNUSED)
            item_count++;
    endtask

    task automatic add_push(input logic [DATA_W-1:0] v);
        add_token('{command: CMD_PUSH, value: v, op: 2'($urandom_range(0, 3))});
    endtask

    task automatic add_oper(input logic [1:0] o);
        add_token('{command: CMD_OPER, value: $urandom, op: o});
    endtask

    task automatic add_end();
        add_token('{command: CMD_END, value: $urandom, op: 2'($urandom_range(0, 3))});
    endtask

    task automatic add_noise();
        add_token('{command: 2'($urandom_range(0, 3)), value: pick_value(),
                    op: 2'($urandom_range(0, 3))});
    endtask

    task automatic queue_expression();
        int depth;
        int steps;
        int ceiling;
        bit deep;
        depth   = 0;
        deep    = ($urandom_range(0, 99) < 3);
        ceiling = deep ? $urandom_range(60, 68) : $urandom_range(2, 8);
        steps   = deep ? ceiling : $urandom_range(1, 14);
        for (int i = 0; i < steps; i++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                add_noise();
            end
            else if (deep || depth < 2 || (depth < ceiling && $urandom_range(0, 1) == 1))
            begin
                add_push(pick_value());
                depth++;
            end
            else
            begin
                add_oper(2'($urandom_range(0, 3)));
                depth--;
            end
        end
        if ($urandom_range(0, 99) < 90)
        begin
            while (depth > 1)
            begin
                add_oper(2'($urandom_range(0, 3)));
                depth--;
            end
        end
        add_end();
    endtask

    task automatic queue_directed();
        add_push(32'h7FFF_FFFF);
        add_push(32'h0000_0001);
        add_oper(OP_ADD);
        add_end();
        add_push(32'h8000_0000);
        add_push(32'hFFFF_FFFF);
        add_oper(OP_DIV);
        add_end();
        add_push(-32'sd7);
        add_push(32'sd2);
        add_oper(OP_DIV);
        add_push(32'sd5);
        add_oper(OP_MUL);
        add_end();
        add_push(32'sd9);
        add_push(32'sd0);
        add_oper(OP_DIV);
        add_oper(OP_ADD);
        add_end();
        add_oper(OP_MUL);
        add_end();
        add_token('{command: CMD_UNUSED, value: 32'hFFFF_FFFF, op: OP_DIV});
        add_push(32'sd1);
        add_push(32'sd2);
        add_push(32'sd3);
        add_oper(OP_SUB);
        add_end();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (token_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_token = token_q.pop_front();
                in_valid   <= 1'b1;
                command    <= next_token.command;
                value      <= next_token.value;
                op         <= next_token.op;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    flag_error($sformatf("unexpected result: answer %0d status %0d",
                                         answer, status));
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (answer !== want.answer)
                        flag_error($sformatf("answer mismatch: expected %0d, got %0d",
                                             $signed(want.answer), answer));
                    if (status !== want.status)
                        flag_error($sformatf("status mismatch: expected %0d, got %0d",
                                             want.status, status));
                end
            end
            if (in_valid && in_ready)
                evaluate_token('{command: command, value: value, op: op});
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                quiet_cycles++;
            end
        end
    end

    initial
    begin
        int phase_start;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                queue_directed();
            phase_start = item_count;
            while (item_count - phase_start < PHASE_ITEMS)
                queue_expression();
            // hold the next phase until every token is sent and every pending answer has drained
            while (token_q.size() != 0 || in_valid || pending_answers.size() != 0)
                @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- postfix_expression_evaluator.f -----
rtl/pfx_pkg.sv
rtl/pfx_alu.sv
rtl/postfix_expression_evaluator.sv
rtl/pfx_checker.sv
test/postfix_expression_evaluator_test.sv
